@@ hdl/pis_pkg.sv @@
// Package: shared types, codes and constant tables of the photon interaction selector.
package pis_pkg;

  localparam int MaxElements = 32;
  localparam logic [31:0] ExpM1Q32 = 32'd1580030169;
  localparam logic [3:0] HornerTerms = 4'd13;
  localparam logic [39:0] ColumnReset = 40'd16777216;

  typedef struct packed {
    logic        func;
    logic [3:0]  element_index;
    logic [47:0] element_xsec;
    logic [47:0] compton_xsec;
    logic [31:0] rand_interact;
    logic [31:0] rand_process;
  } pis_in_t;

  typedef struct packed {
    logic [3:0]  process;
    logic [39:0] total_depth;
  } pis_out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CPT, S_EL1, S_EL2, S_ZCHK, S_HX, S_HD, S_HC, S_EK, S_DEC, S_PM, S_SRCH,
    S_RES
  } pis_state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_ACCEPT, OP_CPT, OP_EL1, OP_EL2, OP_ZINIT, OP_HX, OP_HD, OP_HC, OP_EK,
    OP_DEC, OP_PM, OP_SRCH, OP_RES
  } pis_op_t;

  typedef struct packed {
    pis_op_t op;
    logic    start;
    logic    commit;
  } pis_cmd_t;

  typedef struct packed {
    logic in_eval;
    logic mul_done;
    logic last_el;
    logic total_zero;
    logic n_one;
    logic k_zero;
    logic interact;
    logic hit;
    logic last_i;
    logic out_free;
  } pis_status_t;

  // abundances, unsigned 0.40
  function automatic logic [39:0] abund(input logic [4:0] idx);
    logic [39:0] v;
    case (idx)
      5'd0:    v = 40'd269380349;
      5'd1:    v = 40'd590437744;
      5'd2:    v = 40'd123145302;
      5'd3:    v = 40'd38153053;
      5'd4:    v = 40'd36393835;
      5'd5:    v = 40'd15173260;
      5'd6:    v = 40'd3474457;
      5'd7:    v = 40'd2352955;
      5'd8:    v = 40'd480487;
      5'd9:    v = 40'd31006228;
      5'd10:   v = 40'd1869170;
      default: v = 40'd0;
    endcase
    return v;
  endfunction

  // floor(2^36 / n)
  function automatic logic [36:0] recip(input logic [3:0] n);
    logic [36:0] v;
    case (n)
      4'd1:    v = 37'd68719476736;
      4'd2:    v = 37'd34359738368;
      4'd3:    v = 37'd22906492245;
      4'd4:    v = 37'd17179869184;
      4'd5:    v = 37'd13743895347;
      4'd6:    v = 37'd11453246122;
      4'd7:    v = 37'd9817068105;
      4'd8:    v = 37'd8589934592;
      4'd9:    v = 37'd7635497415;
      4'd10:   v = 37'd6871947673;
      4'd11:   v = 37'd6247225157;
      4'd12:   v = 37'd5726623061;
      4'd13:   v = 37'd5286113595;
      default: v = 37'd0;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/pis_mul.sv @@
// Shared 48x48 multiplier, one 48x16 partial product per cycle.
module pis_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] a,
  input  logic [47:0] b,
  output logic        done,
  output logic [95:0] product
);
  logic [47:0] a_r, b_r;
  logic [95:0] acc_r;
  logic [1:0]  cnt_r;
  logic        busy_r, done_r;
  logic [63:0] pp;
  logic [95:0] pp_sh;

  assign pp = a_r * b_r[15:0];

  always_comb begin
    case (cnt_r)
      2'd0:    pp_sh = {32'd0, pp};
      2'd1:    pp_sh = {16'd0, pp, 16'd0};
      default: pp_sh = {pp, 32'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 2'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd2) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_r + pp_sh;
      b_r   <= {16'd0, b_r[47:16]};
    end
  end

  assign done    = done_r;
  assign product = acc_r;
endmodule

@@ hdl/pis_datapath.sv @@
// Datapath: cross section store, cumulative depths, exponential and process search.
module pis_datapath #(
  parameter int NUM_ELEMENTS = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  pis_pkg::pis_cmd_t    cmd,
  output pis_pkg::pis_status_t status,
  input  pis_pkg::pis_in_t in_data,
  input  logic             cfg_we,
  input  logic [39:0]      cfg_data,
  output logic             out_valid,
  input  logic             out_stall,
  output pis_pkg::pis_out_t out_data
);
  import pis_pkg::*;

  localparam int IW = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
  localparam int CW = $clog2(NUM_ELEMENTS + 1);

  logic [47:0] xsec_r [NUM_ELEMENTS];
  logic [NUM_ELEMENTS-1:0] xv_r;
  logic [39:0] cum_r [NUM_ELEMENTS + 1];
  logic [39:0] cd_r, acc_r;
  logic [47:0] t_r;
  pis_in_t     item_r;
  logic [CW-1:0] i_r;
  logic [31:0] x_r;
  logic [32:0] r_r, y_r, q0_r;
  logic [3:0]  n_r;
  logic [5:0]  k_r;
  logic [3:0]  proc_r;
  logic [71:0] prod_r;
  logic        out_valid_r;
  pis_out_t    out_r;

  logic [47:0] mul_a, mul_b;
  logic        mul_done;
  logic [95:0] p;
  logic [5:0]  i6, ld6;
  logic [47:0] xsec_rd;
  logic [39:0] p24_sat, el_sum_sat;
  logic [40:0] el_sum;
  logic [36:0] qn, rem;
  logic [32:0] q;
  logic [32:0] one_minus_r;
  logic [15:0] kint;

  assign i6  = 6'(i_r);
  assign ld6 = {2'b00, in_data.element_index};
  assign xsec_rd = xv_r[i6[IW-1:0]] ? xsec_r[i6[IW-1:0]] : 48'd0;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_CPT: begin mul_a = {8'd0, cd_r};  mul_b = item_r.compton_xsec; end
      OP_EL1: begin mul_a = xsec_rd;       mul_b = {8'd0, abund(i6[4:0])}; end
      OP_EL2: begin mul_a = t_r;           mul_b = {8'd0, cd_r}; end
      OP_HX:  begin mul_a = {16'd0, x_r};  mul_b = {15'd0, r_r}; end
      OP_HD:  begin mul_a = {15'd0, y_r};  mul_b = {11'd0, recip(n_r)}; end
      OP_EK:  begin mul_a = {15'd0, r_r};  mul_b = {16'd0, ExpM1Q32}; end
      OP_PM:  begin mul_a = {16'd0, item_r.rand_process}; mul_b = {8'd0, acc_r}; end
      default: ;
    endcase
  end

  pis_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (p)
  );

  assign p24_sat    = (p[95:64] != 32'd0) ? {40{1'b1}} : p[63:24];
  assign el_sum     = {1'b0, acc_r} + {1'b0, p24_sat};
  assign el_sum_sat = el_sum[40] ? {40{1'b1}} : el_sum[39:0];
  assign qn         = q0_r * n_r;
  assign rem        = {4'd0, y_r} - qn;
  assign q          = (rem >= 37'(n_r)) ? q0_r + 33'd1 : q0_r;
  assign one_minus_r = 33'h1_0000_0000 - r_r;
  assign kint       = acc_r[39:24];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xv_r        <= '0;
      cd_r        <= ColumnReset;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) cd_r <= cfg_data;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (cmd.op == OP_ACCEPT && !in_data.func && ld6 < 6'(NUM_ELEMENTS))
        xv_r[ld6[IW-1:0]] <= 1'b1;
      if (cmd.op == OP_RES && cmd.commit) out_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_ACCEPT) begin
      item_r <= in_data;
      if (!in_data.func && ld6 < 6'(NUM_ELEMENTS))
        xsec_r[ld6[IW-1:0]] <= in_data.element_xsec;
    end
    if (cmd.commit) begin
      case (cmd.op)
        OP_CPT: begin
          acc_r    <= p24_sat;
          cum_r[0] <= p24_sat;
          i_r      <= '0;
        end
        OP_EL1: t_r <= p[87:40];
        OP_EL2: begin
          acc_r            <= el_sum_sat;
          cum_r[i_r + 1'b1] <= el_sum_sat;
          i_r              <= i_r + 1'b1;
        end
        OP_ZINIT: begin
          x_r    <= {acc_r[23:0], 8'd0};
          r_r    <= 33'h1_0000_0000;
          n_r    <= HornerTerms;
          k_r    <= (kint > 16'd32) ? 6'd32 : kint[5:0];
          proc_r <= 4'd0;
          i_r    <= '0;
        end
        OP_HX: y_r  <= p[64:32];
        OP_HD: q0_r <= p[68:36];
        OP_HC: begin
          r_r <= 33'h1_0000_0000 - q;
          n_r <= n_r - 4'd1;
        end
        OP_EK: begin
          r_r <= p[64:32];
          k_r <= k_r - 6'd1;
        end
        OP_PM: prod_r <= p[71:0];
        OP_SRCH: begin
          if (status.hit) proc_r <= 4'(i6 + 6'd1);
          i_r <= i_r + 1'b1;
        end
        OP_RES: begin
          out_r.process     <= proc_r;
          out_r.total_depth <= acc_r;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    status.in_eval    = in_data.func;
    status.mul_done   = mul_done;
    status.last_el    = (i6 == 6'(NUM_ELEMENTS - 1));
    status.total_zero = (acc_r == 40'd0);
    status.n_one      = (n_r == 4'd1);
    status.k_zero     = (k_r == 6'd0);
    status.interact   = ({1'b0, item_r.rand_interact} <= one_minus_r);
    status.hit        = (prod_r <= {cum_r[i_r], 32'd0});
    status.last_i     = (i6 == 6'(NUM_ELEMENTS));
    status.out_free   = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule

@@ hdl/pis_ctrl.sv @@
// Controller: sequences loads, depth accumulation, exponential and process search.
module pis_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pis_pkg::pis_status_t status,
  output pis_pkg::pis_cmd_t    cmd
);
  import pis_pkg::*;

  pis_state_t state_r, state_nxt;
  logic       issued_r, issued_nxt;
  logic       is_mul;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      issued_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      issued_r <= issued_nxt;
    end
  end

  always_comb begin
    case (state_r)
      S_CPT, S_EL1, S_EL2, S_HX, S_HD, S_EK, S_PM: is_mul = 1'b1;
      default: is_mul = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt  = state_r;
    issued_nxt = issued_r;
    if (is_mul) begin
      if (!issued_r) issued_nxt = 1'b1;
      else if (status.mul_done) issued_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: if (in_valid && status.in_eval) state_nxt = S_CPT;
      S_CPT:  if (status.mul_done) state_nxt = S_EL1;
      S_EL1:  if (status.mul_done) state_nxt = S_EL2;
      S_EL2:  if (status.mul_done) state_nxt = status.last_el ? S_ZCHK : S_EL1;
      S_ZCHK: state_nxt = status.total_zero ? S_RES : S_HX;
      S_HX:   if (status.mul_done) state_nxt = S_HD;
      S_HD:   if (status.mul_done) state_nxt = S_HC;
      S_HC:   state_nxt = status.n_one ? S_EK : S_HX;
      S_EK: begin
        if (status.k_zero) state_nxt = S_DEC;
        else if (status.mul_done) state_nxt = S_EK;
      end
      S_DEC:  state_nxt = status.interact ? S_PM : S_RES;
      S_PM:   if (status.mul_done) state_nxt = S_SRCH;
      S_SRCH: if (status.hit || status.last_i) state_nxt = S_RES;
      S_RES:  if (status.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    // power steps stop once the count is spent
    if (state_r == S_EK && status.k_zero) issued_nxt = 1'b0;
  end

  // outputs
  always_comb begin
    cmd.op     = OP_NONE;
    cmd.start  = is_mul && !issued_r && !(state_r == S_EK && status.k_zero);
    cmd.commit = 1'b0;
    in_stall   = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin cmd.op = in_valid ? OP_ACCEPT : OP_NONE; end
      S_CPT:  begin cmd.op = OP_CPT; cmd.commit = status.mul_done; end
      S_EL1:  begin cmd.op = OP_EL1; cmd.commit = status.mul_done; end
      S_EL2:  begin cmd.op = OP_EL2; cmd.commit = status.mul_done; end
      S_ZCHK: begin cmd.op = OP_ZINIT; cmd.commit = 1'b1; end
      S_HX:   begin cmd.op = OP_HX; cmd.commit = status.mul_done; end
      S_HD:   begin cmd.op = OP_HD; cmd.commit = status.mul_done; end
      S_HC:   begin cmd.op = OP_HC; cmd.commit = 1'b1; end
      S_EK:   begin cmd.op = OP_EK; cmd.commit = status.mul_done && !status.k_zero; end
      S_DEC:  begin cmd.op = OP_DEC; end
      S_PM:   begin cmd.op = OP_PM; cmd.commit = status.mul_done; end
      S_SRCH: begin cmd.op = OP_SRCH; cmd.commit = 1'b1; end
      S_RES:  begin cmd.op = OP_RES; cmd.commit = status.out_free; end
      default: ;
    endcase
  end
endmodule

@@ hdl/photon_interaction_selector.sv @@
// Top level of the photon interaction selector.
// A load word (func 0) writes one element cross section. An evaluate word (func 1)
// runs a sequence on one shared 48x48 multiplier: the Compton depth, two products per
// element, thirteen Horner steps of exp(-fraction) at two products and one correction
// step each, k = min(floor(depth),32) powers of exp(-1), and, if the photon interacts,
// the random scale of the total, then a search over the cumulative depths at one
// interval per cycle. A zero total depth ends the sequence early.
// Words are taken one at a time; the result register lets the next word in while a
// result is still stalled. column_density may be written at any idle time.
module photon_interaction_selector #(
  parameter int NUM_ELEMENTS = 11
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pis_pkg::pis_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pis_pkg::pis_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [39:0]       cfg_data
);
  import pis_pkg::*;

  pis_cmd_t    cmd;
  pis_status_t status;

  assign cfg_ready = 1'b1;

  pis_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  pis_datapath #(.NUM_ELEMENTS(NUM_ELEMENTS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );
endmodule
